/* src/tfr_pkg.sv */
// shared types and constants for the telemetry frame receiver
// no dependencies
package tfr_pkg;

	localparam logic [3:0] KIND_QUERY     = 4'd0;
	localparam logic [3:0] KIND_TELEMETRY = 4'd1;
	localparam logic [3:0] KIND_HEARTBEAT = 4'd2;
	localparam logic [3:0] KIND_ACK       = 4'd3;
	localparam logic [3:0] KIND_PAIR_ACK  = 4'd4;
	localparam logic [3:0] KIND_OTHER     = 4'd5;
	localparam logic [3:0] KIND_SHORT     = 4'd6;
	localparam logic [3:0] KIND_BAD_HDR   = 4'd7;
	localparam logic [3:0] KIND_TRUNC     = 4'd8;
	localparam logic [3:0] KIND_CRC_ERR   = 4'd9;

	localparam logic [2:0] REG_VERSION  = 3'd0;
	localparam logic [2:0] REG_TELE     = 3'd1;
	localparam logic [2:0] REG_HBEAT    = 3'd2;
	localparam logic [2:0] REG_ACK      = 3'd3;
	localparam logic [2:0] REG_PAIR_ACK = 3'd4;
	localparam logic [2:0] REG_TIMEOUT  = 3'd5;

	localparam logic [7:0]  MAGIC_BYTE = 8'h4C;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// one judged event handed from the front to the back
	typedef struct packed {
		logic        query;
		logic [3:0]  kind;
		logic [15:0] seq;
		logic [15:0] ack_seq;
		logic [7:0]  ack_status;
		logic [47:0] now;
		logic [7:0]  motion;
		logic [31:0] steps;
		logic [15:0] accel;
		logic [7:0]  confidence;
		logic [7:0]  signal;
		logic [7:0]  battery;
	} event_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic        link_ok;
		logic [7:0]  motion;
		logic [31:0] steps;
		logic [15:0] accel;
		logic [7:0]  confidence;
		logic [7:0]  signal;
		logic [7:0]  battery;
		logic [47:0] tele_time;
		logic [15:0] seq;
		logic [15:0] ack_seq;
		logic [7:0]  ack_status;
	} result_t;

	typedef struct packed {
		logic [7:0] version;
		logic [7:0] tele_type;
		logic [7:0] hbeat_type;
		logic [7:0] ack_type;
		logic [7:0] pair_type;
	} codes_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* src/tfr_front.sv */
// front part: byte assembly, crc, capture and frame judgement
// depends on tfr_pkg
module tfr_front #(
	parameter int MAX_FRAME_BYTES = 270
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic                   command,
	input  logic [7:0]             data_byte,
	input  logic                   frame_end,
	input  logic signed [7:0]      link_rssi,
	input  logic                   link_rssi_present,
	input  logic [47:0]            now_ms,
	input  tfr_pkg::codes_t        codes,
	output logic                   ev_valid,
	output tfr_pkg::event_t        ev
);
	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic [15:0]   crc_q;
	logic [15:0]   trailer_q;
	logic [7:0]    hdr_q [12];
	logic [7:0]    pay_q [12];

	logic [9:0]  body;
	logic [PW-1:0] len;
	logic [15:0] crc_next, trailer_next;
	logic [7:0]  hdr_n [12];
	logic [7:0]  pay_n [12];
	logic        in_range;
	logic [9:0]  pos10;
	logic [8:0]  pl;

	assign pos10 = 10'(pos_q);

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			hdr_n[i] = hdr_q[i];
			pay_n[i] = pay_q[i];
		end
		crc_next = crc_q;
		trailer_next = trailer_q;
		in_range = pos10 < 10'(MAX_FRAME_BYTES);
		body = 10'd12 + 10'(hdr_q[11]);
		if (in_range) begin
			if (pos10 < 10'd12) begin
				hdr_n[pos10[3:0]] = data_byte;
				crc_next = tfr_pkg::crc_byte(crc_q, data_byte);
			end else if (pos10 < body) begin
				crc_next = tfr_pkg::crc_byte(crc_q, data_byte);
				if (pos10 < 10'd24)
					pay_n[4'(pos10 - 10'd12)] = data_byte;
			end else if (pos10 == body) begin
				trailer_next = {trailer_q[15:8], data_byte};
			end else if (pos10 == body + 10'd1) begin
				trailer_next = {data_byte, trailer_q[7:0]};
			end
		end
		len = in_range ? pos_q + 1'b1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= tfr_pkg::CRC_INIT;
			trailer_q <= '0;
		end else if (take && !command) begin
			if (frame_end) begin
				pos_q <= '0;
				crc_q <= tfr_pkg::CRC_INIT;
			end else begin
				pos_q <= len;
				crc_q <= crc_next;
			end
			trailer_q <= trailer_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !command) begin
			for (int i = 0; i < 12; i++) begin
				hdr_q[i] <= hdr_n[i];
				pay_q[i] <= pay_n[i];
			end
		end
	end

	// judge from the next-state view so the last byte counts
	always_comb begin
		ev = '0;
		ev.now = now_ms;
		ev.query = command;
		ev.kind = tfr_pkg::KIND_QUERY;
		pl = 9'(hdr_n[11]);
		ev.motion = pay_n[0];
		ev.steps = {pay_n[4], pay_n[3], pay_n[2], pay_n[1]};
		ev.accel = {pay_n[6], pay_n[5]};
		ev.confidence = pay_n[7];
		ev.signal = link_rssi_present ? link_rssi : pay_n[8];
		ev.battery = pay_n[9];
		if (!command) begin
			if (10'(len) < 10'd14) begin
				ev.kind = tfr_pkg::KIND_SHORT;
			end else begin
				ev.seq = {hdr_n[6], hdr_n[5]};
				if (hdr_n[0] != tfr_pkg::MAGIC_BYTE || hdr_n[1] != tfr_pkg::MAGIC_BYTE
						|| hdr_n[2] != codes.version)
					ev.kind = tfr_pkg::KIND_BAD_HDR;
				else if (10'(len) < 10'd14 + 10'(pl))
					ev.kind = tfr_pkg::KIND_TRUNC;
				else if (crc_next != trailer_next)
					ev.kind = tfr_pkg::KIND_CRC_ERR;
				else if (hdr_n[3] == codes.tele_type && pl >= 9'd12)
					ev.kind = tfr_pkg::KIND_TELEMETRY;
				else if (hdr_n[3] == codes.hbeat_type)
					ev.kind = tfr_pkg::KIND_HEARTBEAT;
				else if (hdr_n[3] == codes.ack_type && pl >= 9'd4) begin
					ev.kind = tfr_pkg::KIND_ACK;
					ev.ack_seq = {pay_n[1], pay_n[0]};
					ev.ack_status = pay_n[2];
				end else if (hdr_n[3] == codes.pair_type)
					ev.kind = tfr_pkg::KIND_PAIR_ACK;
				else
					ev.kind = tfr_pkg::KIND_OTHER;
			end
		end
	end

	assign ev_valid = take && (command || frame_end);

endmodule

/* src/tfr_queue.sv */
// short event queue between front and back
// depends on tfr_pkg
module tfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  tfr_pkg::event_t wdata,
	output logic            full,
	output logic            nonempty,
	input  logic            rd,
	output tfr_pkg::event_t rdata
);
	tfr_pkg::event_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

/* src/tfr_back.sv */
// back part: stored telemetry update, link status and result register
// depends on tfr_pkg
module tfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ev_valid,
	input  tfr_pkg::event_t ev,
	output logic            ev_take,
	input  logic [15:0]     timeout,
	output logic            res_valid,
	output tfr_pkg::result_t res,
	input  logic            res_pop
);
	logic [7:0]  motion_q, conf_q, signal_q, batt_q;
	logic [31:0] steps_q;
	logic [15:0] accel_q;
	logic [47:0] tele_time_q, last_q;
	logic        any_q;
	logic        rv_q;
	tfr_pkg::result_t res_q;

	logic        tele, refresh, any_n;
	logic [47:0] last_n, diff;
	tfr_pkg::result_t r;

	assign ev_take = ev_valid && (!rv_q || res_pop);
	assign tele = ev.kind == tfr_pkg::KIND_TELEMETRY && !ev.query;
	assign refresh = !ev.query
		&& (ev.kind == tfr_pkg::KIND_TELEMETRY || ev.kind == tfr_pkg::KIND_HEARTBEAT);
	assign last_n = refresh ? ev.now : last_q;
	assign any_n = any_q || refresh;
	assign diff = ev.now - last_n;

	always_comb begin
		r.kind = ev.kind;
		// time going backwards counts as fresh
		r.link_ok = any_n && (ev.now < last_n || diff < 48'(timeout));
		r.motion = tele ? ev.motion : motion_q;
		r.steps = tele ? ev.steps : steps_q;
		r.accel = tele ? ev.accel : accel_q;
		r.confidence = tele ? ev.confidence : conf_q;
		r.signal = tele ? ev.signal : signal_q;
		r.battery = tele ? ev.battery : batt_q;
		r.tele_time = tele ? ev.now : tele_time_q;
		r.seq = ev.seq;
		r.ack_seq = ev.ack_seq;
		r.ack_status = ev.ack_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= '0;
			steps_q <= '0;
			accel_q <= '0;
			conf_q <= '0;
			signal_q <= 8'h9C;
			batt_q <= '0;
			tele_time_q <= '0;
			last_q <= '0;
			any_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			if (ev_take) begin
				motion_q <= r.motion;
				steps_q <= r.steps;
				accel_q <= r.accel;
				conf_q <= r.confidence;
				signal_q <= r.signal;
				batt_q <= r.battery;
				tele_time_q <= r.tele_time;
				last_q <= last_n;
				any_q <= any_n;
				rv_q <= 1'b1;
			end else if (res_pop) begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) res_q <= r;
	end

	assign res_valid = rv_q;
	assign res = res_q;

endmodule

/* src/telemetry_frame_receiver.sv */
// top level of the telemetry frame receiver
// depends on tfr_pkg, tfr_front, tfr_queue, tfr_back
//
// channel   direction  handshake            payload
// input     in         push / full          command, data_byte, frame_end, link_*, now_ms
// result    out        empty / pop          result_kind .. ack_status
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte or query per cycle while full is low; crc update and capture happen in the accepting cycle
// a judged frame or query passes through a queue entry and then the result register to the result ports
// a two-entry queue decouples the front from the result register; full rises
// only when both are held by an unpopped consumer
// reset clears assembly state and stored telemetry (signal returns to 8'h9C) and loads config defaults
module telemetry_frame_receiver #(
	parameter int MAX_FRAME_BYTES = 270
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic [7:0]         data_byte,
	input  logic               frame_end,
	input  logic signed [7:0]  link_rssi,
	input  logic               link_rssi_present,
	input  logic [47:0]        now_ms,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         result_kind,
	output logic               link_ok,
	output logic [7:0]         motion_code,
	output logic [31:0]        step_total,
	output logic [15:0]        accel_peak,
	output logic [7:0]         confidence_level,
	output logic signed [7:0]  signal_dbm,
	output logic [7:0]         battery_level,
	output logic [47:0]        telemetry_time_ms,
	output logic [15:0]        frame_sequence,
	output logic [15:0]        acked_sequence,
	output logic [7:0]         ack_status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	tfr_pkg::codes_t  codes_q;
	logic [15:0]      timeout_q;
	logic             take, ev_valid, q_full, q_ne, q_rd, res_valid, pop_ok;
	tfr_pkg::event_t  ev, q_ev;
	tfr_pkg::result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.version <= 8'd1;
			codes_q.tele_type <= 8'd1;
			codes_q.hbeat_type <= 8'd4;
			codes_q.ack_type <= 8'd3;
			codes_q.pair_type <= 8'd6;
			timeout_q <= 16'd5000;
		end else if (cfg_valid) begin
			case (cfg_index)
				tfr_pkg::REG_VERSION:  codes_q.version <= cfg_data[7:0];
				tfr_pkg::REG_TELE:     codes_q.tele_type <= cfg_data[7:0];
				tfr_pkg::REG_HBEAT:    codes_q.hbeat_type <= cfg_data[7:0];
				tfr_pkg::REG_ACK:      codes_q.ack_type <= cfg_data[7:0];
				tfr_pkg::REG_PAIR_ACK: codes_q.pair_type <= cfg_data[7:0];
				tfr_pkg::REG_TIMEOUT:  timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full = q_full;
	assign take = push && !q_full;

	tfr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk, .arst_n, .take, .command, .data_byte, .frame_end, .link_rssi,
		.link_rssi_present, .now_ms, .codes(codes_q), .ev_valid, .ev
	);

	tfr_queue u_queue (
		.clk, .arst_n, .wr(ev_valid), .wdata(ev), .full(q_full), .nonempty(q_ne),
		.rd(q_rd), .rdata(q_ev)
	);

	assign pop_ok = pop && res_valid;

	tfr_back u_back (
		.clk, .arst_n, .ev_valid(q_ne), .ev(q_ev), .ev_take(q_rd), .timeout(timeout_q),
		.res_valid, .res, .res_pop(pop_ok)
	);

	assign empty = !res_valid;
	assign result_kind = res.kind;
	assign link_ok = res.link_ok;
	assign motion_code = res.motion;
	assign step_total = res.steps;
	assign accel_peak = res.accel;
	assign confidence_level = res.confidence;
	assign signal_dbm = res.signal;
	assign battery_level = res.battery;
	assign telemetry_time_ms = res.tele_time;
	assign frame_sequence = res.seq;
	assign acked_sequence = res.ack_seq;
	assign ack_status = res.ack_status;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !ev_valid) else $error("queue overflow");
	a_take_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_ne) else $error("read of empty queue");
	a_result_appears: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> !empty) else $error("result lost");

endmodule
